>>> rtl/core/epdf_pkg.sv
// Shared types and constants for the escaped packet deframer.
package epdf_pkg;

   // Deframer phase
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   // Result kind codes
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   // Header element positions
   localparam logic [1:0] HDR_CMD_LO = 2'd0;
   localparam logic [1:0] HDR_CMD_HI = 2'd1;
   localparam logic [1:0] HDR_LENGTH = 2'd2;
   localparam logic [1:0] HDR_PAGE   = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [1:0] CSR_ESCAPE_BYTE   = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_MASK   = 2'd2;
   localparam logic [1:0] CSR_PAYLOAD_LIMIT = 2'd3;

   // Register reset values
   localparam logic [7:0] START_BYTE_RST    = 8'h02;
   localparam logic [7:0] ESCAPE_BYTE_RST   = 8'h10;
   localparam logic [7:0] ESCAPE_MASK_RST   = 8'h80;
   localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd63;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] escape_byte;
      logic [7:0] escape_mask;
      logic [7:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] command_code;
      logic [7:0]  payload_length;
      logic [1:0]  kind;
      logic        last;
   } result_type;

endpackage

>>> rtl/core/epdf_input_stage.sv
// Input register holding one received byte until the parser takes it.
module epdf_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import epdf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       accept;

   // Stall only while a held beat cannot move on
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

>>> rtl/core/epdf_parser.sv
// Deframing state machine: unescape, header capture, payload count, checksum.
module epdf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           rx_byte,
   input  epdf_pkg::cfg_type    cfg,
   output logic                 has_result,
   output epdf_pkg::result_type result
);
   import epdf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic        elem_valid;
   logic [7:0]  elem;
   logic [7:0]  cnt_inc;

   // Element after unescape
   assign elem_valid = esc_ff || (rx_byte != cfg.escape_byte);
   assign elem       = esc_ff ? (rx_byte & ~cfg.escape_mask) : rx_byte;
   assign cnt_inc    = cnt_ff + 8'd1;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         esc_ff   <= 1'b0;
         hidx_ff  <= HDR_CMD_LO;
      end else if (fire) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         hidx_ff  <= hidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cmd_ff <= cmd_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   // Next state and result
   always_comb begin
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      hidx_in    = hidx_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      has_result = 1'b0;
      result.payload_byte   = 8'd0;
      result.command_code   = cmd_ff;
      result.payload_length = len_ff;
      result.kind           = KIND_PAYLOAD;
      result.last           = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.start_byte) begin
               phase_in = PH_HEADER;
               esc_in   = 1'b0;
               hidx_in  = HDR_CMD_LO;
               cmd_in   = 16'd0;
               len_in   = 8'd0;
               cnt_in   = 8'd0;
               sum_in   = rx_byte;
            end
         end
         PH_HEADER: begin
            sum_in = sum_ff + rx_byte;
            esc_in = !esc_ff && (rx_byte == cfg.escape_byte);
            if (elem_valid) begin
               case (hidx_ff)
                  HDR_CMD_LO: cmd_in[7:0]  = elem;
                  HDR_CMD_HI: cmd_in[15:8] = elem;
                  HDR_LENGTH: len_in = (elem > cfg.payload_limit) ? cfg.payload_limit : elem;
                  default:    ; // page element is ignored
               endcase
               if (hidx_ff == HDR_PAGE) begin
                  hidx_in  = HDR_CMD_LO;
                  cnt_in   = 8'd0;
                  phase_in = (len_ff == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end else begin
                  hidx_in = hidx_ff + 2'd1;
               end
            end
         end
         PH_PAYLOAD: begin
            sum_in = sum_ff + rx_byte;
            esc_in = !esc_ff && (rx_byte == cfg.escape_byte);
            if (elem_valid) begin
               has_result          = 1'b1;
               result.payload_byte = elem;
               cnt_in              = cnt_inc;
               if (cnt_inc >= len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
         end
         PH_CHECK: begin
            esc_in = !esc_ff && (rx_byte == cfg.escape_byte);
            if (elem_valid) begin
               has_result  = 1'b1;
               result.kind = (elem == sum_ff) ? KIND_GOOD : KIND_BAD;
               result.last = 1'b1;
               phase_in    = PH_HUNT;
               esc_in      = 1'b0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

endmodule

>>> rtl/core/epdf_output_stage.sv
// Result register: holds one result beat until the consumer takes it.
module epdf_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  epdf_pkg::result_type result,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_payload_byte,
   output logic [15:0]          rsp_command_code,
   output logic [7:0]           rsp_payload_length,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_last
);
   import epdf_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Free when empty or draining this cycle
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = data_ff.payload_byte;
   assign rsp_command_code   = data_ff.command_code;
   assign rsp_payload_length = data_ff.payload_length;
   assign rsp_kind           = data_ff.kind;
   assign rsp_last           = data_ff.last;

endmodule

>>> rtl/core/escaped_packet_deframer.sv
// Top level of the escaped packet deframer.
//
//  channel  | handshake          | beat
//  ---------+--------------------+------------------------------------------
//  req      | req_valid/stall    | rx_byte
//  rsp      | rsp_valid/stall    | payload_byte, command_code, payload_length,
//           |                    | kind, last
//  csr      | csr_write_enable   | csr_index, csr_data
//
// One byte per cycle sustained unless a stalled result holds it; each byte is
// registered in the input register and its result, if any, in the result one.
// Synchronous active-high reset clears all valids and returns to hunting.
// A stalled result blocks only bytes that make a result; bytes that make none
// (hunting, header, escape) still pass the parser while the result waits.
module escaped_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_command_code,
   output logic [7:0]  rsp_payload_length,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import epdf_pkg::*;

   cfg_type    cfg_ff;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       has_result;
   result_type result;
   logic       can_load;
   logic       advance;
   logic       load;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= START_BYTE_RST;
         cfg_ff.escape_byte   <= ESCAPE_BYTE_RST;
         cfg_ff.escape_mask   <= ESCAPE_MASK_RST;
         cfg_ff.payload_limit <= PAYLOAD_LIMIT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_BYTE:    cfg_ff.start_byte    <= csr_data;
            CSR_ESCAPE_BYTE:   cfg_ff.escape_byte   <= csr_data;
            CSR_ESCAPE_MASK:   cfg_ff.escape_mask   <= csr_data;
            CSR_PAYLOAD_LIMIT: cfg_ff.payload_limit <= csr_data;
            default:           ;
         endcase
      end
   end

   // A byte moves on unless its result has nowhere to go
   assign advance = byte_valid && (!has_result || can_load);
   assign load    = advance && has_result;

   epdf_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   epdf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .rx_byte    (byte_data),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   epdf_output_stage u_output (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .result             (result),
      .can_load           (can_load),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_kind           (rsp_kind),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTH
   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // A held byte that cannot advance stays held
   a_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && !advance) |=> byte_valid)
      else $error("input byte lost");

   // Status results carry last, payload results do not
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_PAYLOAD)))
      else $error("last does not match kind");

   // Only defined kinds are sent
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_GOOD ||
                     rsp_kind == KIND_BAD))
      else $error("undefined result kind");
`endif

endmodule

>>> dv/escaped_packet_deframer_tb.sv
// Self-checking testbench for the escaped packet deframer: directed table, then random frames.
module escaped_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import epdf_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int SETTLE_CYCLES  = 6;
   localparam int ITEMS_PER_STEP = 215;
   localparam int NUM_STEPS      = 6;
   localparam int CYCLE_LIMIT    = 300000;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // One row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      result_type want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_command_code;
   logic [7:0]  rsp_payload_length;
   logic [1:0]  rsp_kind;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data = 8'h00;

   escaped_packet_deframer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_kind           (rsp_kind),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Deframer shadow: settings and parser state
   cfg_type     cfg;
   phase_type   frame_phase;
   logic        esc_armed;
   logic [1:0]  hdr_slot;
   logic [15:0] cmd_acc;
   logic [7:0]  len_acc;
   logic [7:0]  pay_seen;
   logic [7:0]  byte_sum;

   result_type  deframed_queue [$];
   logic [7:0]  frame_bytes [$];
   logic [7:0]  plan_sum;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   result_type  seen_result;
   result_type  oldest_result;

   // Directed table: noise while hunting, a good frame, an escaped frame with
   // a start byte inside it and an escaped checksum, then a bad checksum
   script_row_type directed_rows [24] = '{
      '{8'h10, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h34, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hAB, 1'b1, '{8'hAB, 16'h1234, 8'h01, KIND_PAYLOAD, 1'b0}},
      '{8'hF4, 1'b1, '{8'h00, 16'h1234, 8'h01, KIND_GOOD, 1'b1}},
      '{8'h02, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h10, 1'b0, '0},
      '{8'h90, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h10, 1'b0, '0},
      '{8'hA3, 1'b1, '{8'h00, 16'h1002, 8'h00, KIND_GOOD, 1'b1}},
      '{8'h02, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h01, 1'b1, '{8'h00, 16'hFFFF, 8'h00, KIND_BAD, 1'b1}}
   };

   // Settings per random step, extremes among them
   cfg_type step_cfg [NUM_STEPS] = '{
      '{8'h02, 8'h10, 8'h80, 8'd63},
      '{8'h7E, 8'h7D, 8'h20, 8'd8},
      '{8'h00, 8'hFF, 8'hFF, 8'd0},
      '{8'hFF, 8'h00, 8'h00, 8'd255},
      '{8'hAA, 8'h55, 8'h0F, 8'd16},
      '{8'h02, 8'h10, 8'h80, 8'd63}
   };
   idle_mode_type step_mode [NUM_STEPS] = '{
      IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH
   };

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report($sformatf("%s mismatch: got %0h, want %0h", name, got, want));
   endtask

   task automatic clear_deframer();
      cfg         = '{START_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST, PAYLOAD_LIMIT_RST};
      frame_phase = PH_HUNT;
      esc_armed   = 1'b0;
      hdr_slot    = 2'd0;
      cmd_acc     = 16'h0000;
      len_acc     = 8'h00;
      pay_seen    = 8'h00;
      byte_sum    = 8'h00;
   endtask

   // Advance the shadow parser by one raw byte; made is set when a beat results
   task automatic deframe_byte(input logic [7:0] b, output bit made, output result_type r);
      logic [7:0] elem;
      made = 1'b0;
      r    = '0;
      if (frame_phase == PH_HUNT) begin
         if (b == cfg.start_byte) begin
            frame_phase = PH_HEADER;
            esc_armed   = 1'b0;
            hdr_slot    = 2'd0;
            cmd_acc     = 16'h0000;
            len_acc     = 8'h00;
            pay_seen    = 8'h00;
            byte_sum    = b;
         end
         return;
      end
      // sum covers raw bytes through the last payload byte, escapes included
      if (frame_phase != PH_CHECK)
         byte_sum = byte_sum + b;
      if (esc_armed) begin
         esc_armed = 1'b0;
         elem      = b & ~cfg.escape_mask;
      end else if (b == cfg.escape_byte) begin
         esc_armed = 1'b1;
         return;
      end else begin
         elem = b;
      end
      case (frame_phase)
         PH_HEADER: begin
            case (hdr_slot)
               HDR_CMD_LO: cmd_acc[7:0]  = elem;
               HDR_CMD_HI: cmd_acc[15:8] = elem;
               HDR_LENGTH: len_acc = (elem > cfg.payload_limit) ? cfg.payload_limit : elem;
               default: ;
            endcase
            if (hdr_slot == HDR_PAGE) begin
               hdr_slot    = 2'd0;
               pay_seen    = 8'h00;
               frame_phase = (len_acc == 8'h00) ? PH_CHECK : PH_PAYLOAD;
            end else begin
               hdr_slot = hdr_slot + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            made     = 1'b1;
            r        = '{elem, cmd_acc, len_acc, KIND_PAYLOAD, 1'b0};
            pay_seen = pay_seen + 8'd1;
            if (pay_seen >= len_acc)
               frame_phase = PH_CHECK;
         end
         default: begin
            made        = 1'b1;
            r           = '{8'h00, cmd_acc, len_acc,
                            (elem == byte_sum) ? KIND_GOOD : KIND_BAD, 1'b1};
            frame_phase = PH_HUNT;
            esc_armed   = 1'b0;
         end
      endcase
   endtask

   // Offer one byte, wait for the beat, then queue what it should produce
   task automatic send_byte(input logic [7:0] b, input logic typed, input result_type want);
      bit         made;
      result_type r;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      deframe_byte(b, made, r);
      if (typed)
         deframed_queue.push_back(want);
      else if (made)
         deframed_queue.push_back(r);
   endtask

   // Sender holds off until every result is back and the pipe is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (deframed_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      case (idx)
         CSR_START_BYTE:    cfg.start_byte    = data;
         CSR_ESCAPE_BYTE:   cfg.escape_byte   = data;
         CSR_ESCAPE_MASK:   cfg.escape_mask   = data;
         CSR_PAYLOAD_LIMIT: cfg.payload_limit = data;
         default: ;
      endcase
   endtask

   task automatic write_settings(input cfg_type c);
      csr_write(CSR_START_BYTE, c.start_byte);
      csr_write(CSR_ESCAPE_BYTE, c.escape_byte);
      csr_write(CSR_ESCAPE_MASK, c.escape_mask);
      csr_write(CSR_PAYLOAD_LIMIT, c.payload_limit);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idle(input idle_mode_type m);
      case (m)
         IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
         IDLE_BOTH: begin send_idle_pct = 13; recv_stall_pct = 13; end
         default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Append one element, escaping it now and then or when it must be
   task automatic put_elem(input logic [7:0] e, input bit summed, output logic [7:0] got);
      logic [7:0] raw;
      if (e == cfg.escape_byte ||
          ((e & cfg.escape_mask) == 8'h00 && $urandom_range(0, 5) == 0)) begin
         got = e & ~cfg.escape_mask;
         raw = got | (8'($urandom) & cfg.escape_mask);
         frame_bytes.push_back(cfg.escape_byte);
         frame_bytes.push_back(raw);
         if (summed)
            plan_sum = plan_sum + cfg.escape_byte + raw;
      end else begin
         got = e;
         frame_bytes.push_back(e);
         if (summed)
            plan_sum = plan_sum + e;
      end
   endtask

   // Build one frame under the current settings; noise_len leading bytes are line noise
   task automatic plan_packet(output int noise_len);
      logic [7:0] e, got, len_elem, small_max;
      int         n_pay, pick;
      frame_bytes.delete();
      noise_len = 0;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         noise_len = $urandom_range(1, 6);
         repeat (noise_len) frame_bytes.push_back(8'($urandom));
         return;
      end
      if (pick < 30) begin
         noise_len = $urandom_range(1, 3);
         repeat (noise_len) begin
            e = 8'($urandom);
            if (e == cfg.start_byte)
               e = ~e;
            frame_bytes.push_back(e);
         end
      end
      frame_bytes.push_back(cfg.start_byte);
      plan_sum = cfg.start_byte;
      put_elem(8'($urandom), 1'b1, got);
      put_elem(8'($urandom), 1'b1, got);
      // mostly short frames; sometimes oversize lengths that get clamped
      small_max = (cfg.payload_limit < 8'd6) ? cfg.payload_limit : 8'd6;
      pick = $urandom_range(0, 99);
      if (pick < 82)
         len_elem = 8'($urandom_range(0, small_max));
      else if (pick < 91)
         len_elem = 8'($urandom);
      else
         len_elem = cfg.payload_limit;
      put_elem(len_elem, 1'b1, got);
      n_pay = int'((got > cfg.payload_limit) ? cfg.payload_limit : got);
      put_elem(8'($urandom), 1'b1, got);
      repeat (n_pay) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            e = cfg.start_byte;
         else if (pick < 20)
            e = cfg.escape_byte;
         else
            e = 8'($urandom);
         put_elem(e, 1'b1, got);
      end
      e = plan_sum;
      if ($urandom_range(0, 7) == 0)
         e = e ^ (8'h01 << $urandom_range(0, 7));
      put_elem(e, 1'b0, got);
      // now and then a frame breaks off early
      if ($urandom_range(0, 19) == 0)
         frame_bytes = frame_bytes[0:$urandom_range(noise_len, frame_bytes.size() - 1)];
   endtask

   // Random frames to target framed bytes, then a cut-off one that may leave the parser mid-frame
   task automatic run_random(input int target);
      int sent, noise, stop;
      sent = 0;
      while (sent < target) begin
         plan_packet(noise);
         foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b0, '0);
         sent += frame_bytes.size() - noise;
      end
      plan_packet(noise);
      stop = noise + $urandom_range(1, 6);
      foreach (frame_bytes[i])
         if (i < stop)
            send_byte(frame_bytes[i], 1'b0, '0);
   endtask

   // Receiver stall
   always @(posedge clock)
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);

   // Result checking against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result = '{rsp_payload_byte, rsp_command_code, rsp_payload_length,
                         rsp_kind, rsp_last};
         if (deframed_queue.size() == 0) begin
            report($sformatf("result with nothing expected: kind %0d byte %02h",
                             rsp_kind, rsp_payload_byte));
         end else begin
            oldest_result = deframed_queue.pop_front();
            check_field("payload_byte", 16'(seen_result.payload_byte),
                        16'(oldest_result.payload_byte));
            check_field("command_code", seen_result.command_code, oldest_result.command_code);
            check_field("payload_length", 16'(seen_result.payload_length),
                        16'(oldest_result.payload_length));
            check_field("kind", 16'(seen_result.kind), 16'(oldest_result.kind));
            check_field("last", 16'(seen_result.last), 16'(oldest_result.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[escaped_packet_deframer] ERROR");
         $finish;
      end
   end

   // Main sequence
   initial begin
      clear_deframer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idle(IDLE_NONE);
      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
      for (int s = 0; s < NUM_STEPS; s++) begin
         drain();
         write_settings(step_cfg[s]);
         set_idle(step_mode[s]);
         run_random(ITEMS_PER_STEP);
      end
      drain();
      if (mismatch_count == 0)
         $display("[escaped_packet_deframer] OK");
      else
         $display("[escaped_packet_deframer] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/epdf_pkg.sv
rtl/core/epdf_input_stage.sv
rtl/core/epdf_parser.sv
rtl/core/epdf_output_stage.sv
rtl/core/escaped_packet_deframer.sv
dv/escaped_packet_deframer_tb.sv
